/* hdl/lpu_pkg.sv */
// Shared types, constants and the round microcode of the lens point undistorter.
// Used by lpu_mul, lpu_div and lens_point_undistorter. No dependencies.
package lpu_pkg;

    localparam logic [63:0] CAPV = 64'h1000_0000_0000_0000;
    localparam logic [63:0] ONEV = 64'h0000_0001_0000_0000;

    localparam logic [2:0] CFG_INV_FOCAL = 3'd0;
    localparam logic [2:0] CFG_CENTER    = 3'd1;
    localparam logic [2:0] CFG_RAD_DEN   = 3'd2;
    localparam logic [2:0] CFG_RAD_NUM   = 3'd3;
    localparam logic [2:0] CFG_TANG      = 3'd4;
    localparam logic [2:0] CFG_ITER      = 3'd5;
    localparam logic [2:0] CFG_BIN       = 3'd6;

    localparam logic [5:0] PC_LOOP = 6'd4;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_MUL,
        OP_DIV,
        OP_LOOP,
        OP_CHK,
        OP_NEXT
    } op_t;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_ONE, SRC_X0, SRC_Y0, SRC_X, SRC_Y, SRC_XX, SRC_YY,
        SRC_XY, SRC_R2, SRC_NUM, SRC_DEN, SRC_F, SRC_T1, SRC_T2, SRC_DX,
        SRC_DY, SRC_TMP, SRC_K1, SRC_K2, SRC_K3, SRC_K4, SRC_K5, SRC_K6,
        SRC_P1, SRC_P2, SRC_NX, SRC_NY, SRC_IFX, SRC_IFY
    } src_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        logic neg_b;
        src_t dst;
    } uop_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } lpu_req_t;

    typedef struct packed {
        logic        done;
        logic        clip;
        logic [63:0] value;
    } lpu_res_t;

    function automatic uop_t mk(input op_t op, input src_t a, input src_t b,
                                input logic neg_b, input src_t dst);
        uop_t u;
        u.op    = op;
        u.a     = a;
        u.b     = b;
        u.neg_b = neg_b;
        u.dst   = dst;
        return u;
    endfunction

    function automatic uop_t lpu_uop(input logic [5:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = mk(OP_MUL,  SRC_NX,  SRC_IFX,  1'b0, SRC_X0);
            6'd1:  u = mk(OP_MUL,  SRC_NY,  SRC_IFY,  1'b0, SRC_Y0);
            6'd2:  u = mk(OP_ADD,  SRC_X0,  SRC_ZERO, 1'b0, SRC_X);
            6'd3:  u = mk(OP_ADD,  SRC_Y0,  SRC_ZERO, 1'b0, SRC_Y);
            6'd4:  u = mk(OP_LOOP, SRC_ZERO, SRC_ZERO, 1'b0, SRC_ZERO);
            6'd5:  u = mk(OP_MUL,  SRC_X,   SRC_X,    1'b0, SRC_XX);
            6'd6:  u = mk(OP_MUL,  SRC_Y,   SRC_Y,    1'b0, SRC_YY);
            6'd7:  u = mk(OP_MUL,  SRC_X,   SRC_Y,    1'b0, SRC_XY);
            6'd8:  u = mk(OP_ADD,  SRC_XX,  SRC_YY,   1'b0, SRC_R2);
            6'd9:  u = mk(OP_MUL,  SRC_K6,  SRC_R2,   1'b0, SRC_TMP);
            6'd10: u = mk(OP_ADD,  SRC_TMP, SRC_K5,   1'b0, SRC_TMP);
            6'd11: u = mk(OP_MUL,  SRC_TMP, SRC_R2,   1'b0, SRC_TMP);
            6'd12: u = mk(OP_ADD,  SRC_TMP, SRC_K4,   1'b0, SRC_TMP);
            6'd13: u = mk(OP_MUL,  SRC_TMP, SRC_R2,   1'b0, SRC_TMP);
            6'd14: u = mk(OP_ADD,  SRC_ONE, SRC_TMP,  1'b0, SRC_NUM);
            6'd15: u = mk(OP_MUL,  SRC_K3,  SRC_R2,   1'b0, SRC_TMP);
            6'd16: u = mk(OP_ADD,  SRC_TMP, SRC_K2,   1'b0, SRC_TMP);
            6'd17: u = mk(OP_MUL,  SRC_TMP, SRC_R2,   1'b0, SRC_TMP);
            6'd18: u = mk(OP_ADD,  SRC_TMP, SRC_K1,   1'b0, SRC_TMP);
            6'd19: u = mk(OP_MUL,  SRC_TMP, SRC_R2,   1'b0, SRC_TMP);
            6'd20: u = mk(OP_ADD,  SRC_ONE, SRC_TMP,  1'b0, SRC_DEN);
            6'd21: u = mk(OP_CHK,  SRC_NUM, SRC_DEN,  1'b0, SRC_ZERO);
            6'd22: u = mk(OP_DIV,  SRC_NUM, SRC_DEN,  1'b0, SRC_F);
            6'd23: u = mk(OP_MUL,  SRC_P1,  SRC_XY,   1'b0, SRC_T1);
            6'd24: u = mk(OP_MUL,  SRC_P2,  SRC_XY,   1'b0, SRC_T2);
            6'd25: u = mk(OP_ADD,  SRC_T1,  SRC_T1,   1'b0, SRC_DX);
            6'd26: u = mk(OP_ADD,  SRC_XX,  SRC_XX,   1'b0, SRC_TMP);
            6'd27: u = mk(OP_ADD,  SRC_R2,  SRC_TMP,  1'b0, SRC_TMP);
            6'd28: u = mk(OP_MUL,  SRC_P2,  SRC_TMP,  1'b0, SRC_TMP);
            6'd29: u = mk(OP_ADD,  SRC_DX,  SRC_TMP,  1'b0, SRC_DX);
            6'd30: u = mk(OP_ADD,  SRC_YY,  SRC_YY,   1'b0, SRC_TMP);
            6'd31: u = mk(OP_ADD,  SRC_R2,  SRC_TMP,  1'b0, SRC_TMP);
            6'd32: u = mk(OP_MUL,  SRC_P1,  SRC_TMP,  1'b0, SRC_DY);
            6'd33: u = mk(OP_ADD,  SRC_T2,  SRC_T2,   1'b0, SRC_TMP);
            6'd34: u = mk(OP_ADD,  SRC_DY,  SRC_TMP,  1'b0, SRC_DY);
            6'd35: u = mk(OP_ADD,  SRC_X0,  SRC_DX,   1'b1, SRC_TMP);
            6'd36: u = mk(OP_MUL,  SRC_TMP, SRC_F,    1'b0, SRC_X);
            6'd37: u = mk(OP_ADD,  SRC_Y0,  SRC_DY,   1'b1, SRC_TMP);
            6'd38: u = mk(OP_MUL,  SRC_TMP, SRC_F,    1'b0, SRC_Y);
            default: u = mk(OP_NEXT, SRC_ZERO, SRC_ZERO, 1'b0, SRC_ZERO);
        endcase
        return u;
    endfunction

endpackage

/* hdl/lpu_mul.sv */
// Sequential Q32 multiplier: one 32x32 partial product per cycle, clamp to 2^60.
// Depends on lpu_pkg.
module lpu_mul
    import lpu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  lpu_req_t req,
    output lpu_res_t res
);

    typedef enum logic [1:0] {M_IDLE, M_ACC, M_FIN} mstate_t;

    mstate_t      state_reg;
    logic [1:0]   cnt_reg;
    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    lpu_res_t     res_reg;

    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [63:0]  mag;
    logic         ovf;

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    begin pa = ma_reg[31:0];  pb = mb_reg[31:0];  end
            2'd1:    begin pa = ma_reg[31:0];  pb = mb_reg[63:32]; end
            2'd2:    begin pa = ma_reg[63:32]; pb = mb_reg[31:0];  end
            default: begin pa = ma_reg[63:32]; pb = mb_reg[63:32]; end
        endcase
        pp = {32'd0, pa} * {32'd0, pb};
        unique case (cnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1,
            2'd2:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        ovf = (acc_reg[127:96] != 32'd0) || (acc_reg[95:32] > CAPV);
        mag = ovf ? CAPV : acc_reg[95:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= M_IDLE;
            cnt_reg      <= 2'd0;
            res_reg.done <= 1'b0;
        end
        else
        begin
            res_reg.done <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        ma_reg    <= req.a[63] ? (~req.a + 64'd1) : req.a;
                        mb_reg    <= req.b[63] ? (~req.b + 64'd1) : req.b;
                        neg_reg   <= req.a[63] ^ req.b[63];
                        acc_reg   <= 128'd0;
                        cnt_reg   <= 2'd0;
                        state_reg <= M_ACC;
                    end
                end
                M_ACC:
                begin
                    acc_reg <= acc_reg + pp_sh;
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= M_FIN;
                    end
                end
                default:
                begin
                    res_reg.done  <= 1'b1;
                    res_reg.clip  <= ovf;
                    res_reg.value <= neg_reg ? (~mag + 64'd1) : mag;
                    state_reg     <= M_IDLE;
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

/* hdl/lpu_div.sv */
// Bit-serial restoring divider: (mn * 2^32) / md on magnitudes, one quotient bit a cycle.
// Depends on lpu_pkg.
module lpu_div
    import lpu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  lpu_req_t req,
    output lpu_res_t res
);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t     state_reg;
    logic [6:0]  cnt_reg;
    logic [95:0] sh_reg;
    logic [63:0] md_reg, r_reg, q_reg;
    logic        ovf_reg;
    lpu_res_t    res_reg;

    logic [63:0] r_sh;
    logic        take;

    always_comb
    begin
        r_sh = {r_reg[62:0], sh_reg[95]};
        take = r_reg[63] || (r_sh >= md_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= D_IDLE;
            cnt_reg      <= 7'd0;
            res_reg.done <= 1'b0;
        end
        else
        begin
            res_reg.done <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        if (req.b == 64'd0)
                        begin
                            // zero divisor: zero over zero is zero, else saturate
                            res_reg.done  <= 1'b1;
                            res_reg.clip  <= (req.a != 64'd0);
                            res_reg.value <= (req.a != 64'd0) ? CAPV : 64'd0;
                        end
                        else
                        begin
                            sh_reg    <= {req.a, 32'd0};
                            md_reg    <= req.b;
                            r_reg     <= 64'd0;
                            q_reg     <= 64'd0;
                            ovf_reg   <= 1'b0;
                            cnt_reg   <= 7'd0;
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    r_reg   <= take ? (r_sh - md_reg) : r_sh;
                    q_reg   <= {q_reg[62:0], take};
                    ovf_reg <= ovf_reg | q_reg[63];
                    sh_reg  <= {sh_reg[94:0], 1'b0};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd95)
                    begin
                        state_reg <= D_FIN;
                    end
                end
                default:
                begin
                    res_reg.done  <= 1'b1;
                    res_reg.clip  <= ovf_reg || (q_reg > CAPV);
                    res_reg.value <= (ovf_reg || (q_reg > CAPV)) ? CAPV : q_reg;
                    state_reg     <= D_IDLE;
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

/* hdl/lens_point_undistorter.sv */
// Lens point undistorter top level: config registers, microcode sequencer, output register.
// Each point runs n = min(iteration_limit, MAX_ITERATIONS) rounds, each with one bit-serial
// divide and fifteen multiplies; a fallback ends the rounds early and a zero divisor ends the
// divide early. A new point is not taken before the last one has reached the output register;
// a point is taken only while the sequencer is idle, and a stalled result holds the sequencer.
// Reset (rst_n, asynchronous, active low) loads the register defaults and idles the block.
module lens_point_undistorter
    import lpu_pkg::*;
#(
    parameter int MAX_ITERATIONS = 31
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        src_x,
    input  logic [15:0]        src_y,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] norm_x,
    output logic signed [31:0] norm_y,
    output logic               fallback_taken,
    output logic               saturated,
    output logic               last_out
);

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;

    // configuration registers
    logic [63:0] ifocal_reg, center_reg, tang_reg;
    logic [62:0] rden_reg, rnum_reg;
    logic [4:0]  iter_reg;
    logic [15:0] bin_reg;

    // sequencer state
    state_t             state_reg;
    logic [5:0]         pc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               clip_reg, fb_reg, last_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_x_reg, out_y_reg;
    logic               out_fb_reg, out_sat_reg, out_last_reg;

    // working registers (Q32 in 64 bits)
    logic [63:0] nx_reg, ny_reg;
    logic [63:0] x0_reg, y0_reg, x_reg, y_reg, xx_reg, yy_reg, xy_reg, r2_reg;
    logic [63:0] num_reg, den_reg, f_reg, t1_reg, t2_reg, dx_reg, dy_reg, tmp_reg;

    uop_t        uop;
    logic [63:0] opa, opb, opb_n, sum, sum_c;
    logic        sum_clip;
    lpu_req_t    mul_req, div_req;
    lpu_res_t    mul_res, div_res;
    logic        wr_en;
    src_t        wr_dst;
    logic [63:0] wr_data;
    logic [CNT_W-1:0] n_eff;
    logic        fb_cond;
    logic [7:0]  bx, by;
    logic [23:0] px, py;
    logic [63:0] dnx, dny;
    logic [63:0] mag_x, mag_y;
    logic        clip_x, clip_y;
    logic [31:0] ox, oy;
    logic        out_load;

    function automatic logic [63:0] kx(input logic [20:0] k);
        return {{29{k[20]}}, k, 14'd0};
    endfunction

    function automatic logic [63:0] magn(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [63:0] src_mux(input src_t s,
        input logic [63:0] x0, input logic [63:0] y0, input logic [63:0] x,
        input logic [63:0] y, input logic [63:0] xx, input logic [63:0] yy,
        input logic [63:0] xy, input logic [63:0] r2, input logic [63:0] num,
        input logic [63:0] den, input logic [63:0] f, input logic [63:0] t1,
        input logic [63:0] t2, input logic [63:0] dx, input logic [63:0] dy,
        input logic [63:0] tmp, input logic [62:0] rden, input logic [62:0] rnum,
        input logic [63:0] tang, input logic [63:0] nx, input logic [63:0] ny,
        input logic [63:0] ifocal);
        logic [63:0] v;
        unique case (s)
            SRC_ZERO: v = 64'd0;
            SRC_ONE:  v = ONEV;
            SRC_X0:   v = x0;
            SRC_Y0:   v = y0;
            SRC_X:    v = x;
            SRC_Y:    v = y;
            SRC_XX:   v = xx;
            SRC_YY:   v = yy;
            SRC_XY:   v = xy;
            SRC_R2:   v = r2;
            SRC_NUM:  v = num;
            SRC_DEN:  v = den;
            SRC_F:    v = f;
            SRC_T1:   v = t1;
            SRC_T2:   v = t2;
            SRC_DX:   v = dx;
            SRC_DY:   v = dy;
            SRC_TMP:  v = tmp;
            SRC_K1:   v = kx(rden[62:42]);
            SRC_K2:   v = kx(rden[41:21]);
            SRC_K3:   v = kx(rden[20:0]);
            SRC_K4:   v = kx(rnum[62:42]);
            SRC_K5:   v = kx(rnum[41:21]);
            SRC_K6:   v = kx(rnum[20:0]);
            SRC_P1:   v = {{30{tang[63]}}, tang[63:32], 2'd0};
            SRC_P2:   v = {{30{tang[31]}}, tang[31:0], 2'd0};
            SRC_NX:   v = nx;
            SRC_NY:   v = ny;
            SRC_IFX:  v = {32'd0, ifocal[63:32]};
            SRC_IFY:  v = {32'd0, ifocal[31:0]};
            default:  v = 64'd0;
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Decode the current microcode step and run the shared adder
    // ---------------------------------------------------------------
    always_comb
    begin
        uop = lpu_uop(pc_reg);
        opa = src_mux(uop.a, x0_reg, y0_reg, x_reg, y_reg, xx_reg, yy_reg, xy_reg,
                      r2_reg, num_reg, den_reg, f_reg, t1_reg, t2_reg, dx_reg,
                      dy_reg, tmp_reg, rden_reg, rnum_reg, tang_reg, nx_reg,
                      ny_reg, ifocal_reg);
        opb = src_mux(uop.b, x0_reg, y0_reg, x_reg, y_reg, xx_reg, yy_reg, xy_reg,
                      r2_reg, num_reg, den_reg, f_reg, t1_reg, t2_reg, dx_reg,
                      dy_reg, tmp_reg, rden_reg, rnum_reg, tang_reg, nx_reg,
                      ny_reg, ifocal_reg);
        opb_n = uop.neg_b ? (~opb + 64'd1) : opb;
        sum   = opa + opb_n;
        // clamp to +/- 2^60
        if (!sum[63] && (sum > CAPV))
        begin
            sum_c    = CAPV;
            sum_clip = 1'b1;
        end
        else if (sum[63] && (magn(sum) > CAPV))
        begin
            sum_c    = ~CAPV + 64'd1;
            sum_clip = 1'b1;
        end
        else
        begin
            sum_c    = sum;
            sum_clip = 1'b0;
        end

        // negative radial factor test
        fb_cond = (num_reg[63] && !den_reg[63] && (den_reg != 64'd0))
               || (!num_reg[63] && (num_reg != 64'd0) && den_reg[63])
               || (num_reg[63] && (den_reg == 64'd0));

        mul_req.start = (state_reg == S_ISSUE) && (uop.op == OP_MUL);
        mul_req.a     = opa;
        mul_req.b     = opb;
        div_req.start = (state_reg == S_ISSUE) && (uop.op == OP_DIV);
        div_req.a     = magn(opa);
        div_req.b     = magn(opb);

        // write-back port of the working registers
        wr_dst = uop.dst;
        if ((state_reg == S_ISSUE) && (uop.op == OP_ADD))
        begin
            wr_en   = 1'b1;
            wr_data = sum_c;
        end
        else if ((state_reg == S_WAIT) && (mul_res.done || div_res.done))
        begin
            wr_en   = 1'b1;
            wr_data = mul_res.done ? mul_res.value : div_res.value;
        end
        else
        begin
            wr_en   = 1'b0;
            wr_data = sum_c;
        end
    end

    always_comb
    begin
        if (int'(iter_reg) > MAX_ITERATIONS)
        begin
            n_eff = CNT_W'(MAX_ITERATIONS);
        end
        else
        begin
            n_eff = CNT_W'(iter_reg);
        end

        // normalize operands: (coord*bin - center) in Q12, shifted up to Q28 for the focal multiply
        bx  = (bin_reg[15:8] == 8'd0) ? 8'd1 : bin_reg[15:8];
        by  = (bin_reg[7:0] == 8'd0) ? 8'd1 : bin_reg[7:0];
        px  = {8'd0, src_x} * {16'd0, bx};
        py  = {8'd0, src_y} * {16'd0, by};
        dnx = {28'd0, px, 12'd0} - {32'd0, center_reg[63:32]};
        dny = {28'd0, py, 12'd0} - {32'd0, center_reg[31:0]};

        // output rounding to Q4.28, half away from zero
        mag_x  = (magn(x_reg) + 64'd8) >> 4;
        mag_y  = (magn(y_reg) + 64'd8) >> 4;
        clip_x = x_reg[63] ? (mag_x > 64'h8000_0000) : (mag_x > 64'h7FFF_FFFF);
        clip_y = y_reg[63] ? (mag_y > 64'h8000_0000) : (mag_y > 64'h7FFF_FFFF);
        ox     = clip_x ? (x_reg[63] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                        : (x_reg[63] ? (~mag_x[31:0] + 32'd1) : mag_x[31:0]);
        oy     = clip_y ? (y_reg[63] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                        : (y_reg[63] ? (~mag_y[31:0] + 32'd1) : mag_y[31:0]);

        // load the output register from the output step once it is free
        out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    end

    lpu_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .res   (mul_res)
    );

    lpu_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ifocal_reg <= 64'd0;
            center_reg <= 64'd0;
            rden_reg   <= 63'd0;
            rnum_reg   <= 63'd0;
            tang_reg   <= 64'd0;
            iter_reg   <= 5'd5;
            bin_reg    <= 16'd257;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_INV_FOCAL: ifocal_reg <= cfg_data;
                CFG_CENTER:    center_reg <= cfg_data;
                CFG_RAD_DEN:   rden_reg   <= cfg_data[62:0];
                CFG_RAD_NUM:   rnum_reg   <= cfg_data[62:0];
                CFG_TANG:      tang_reg   <= cfg_data;
                CFG_ITER:      iter_reg   <= cfg_data[4:0];
                CFG_BIN:       bin_reg    <= cfg_data[15:0];
                default:       ;   // drop writes past the last register
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Working registers: input load, one write port, plus the fallback restore
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            nx_reg <= {dnx[47:0], 16'd0};
            ny_reg <= {dny[47:0], 16'd0};
        end
        if ((state_reg == S_ISSUE) && (uop.op == OP_CHK) && fb_cond)
        begin
            x_reg <= x0_reg;
            y_reg <= y0_reg;
        end
        else if (wr_en)
        begin
            unique case (wr_dst)
                SRC_X0:  x0_reg  <= wr_data;
                SRC_Y0:  y0_reg  <= wr_data;
                SRC_X:   x_reg   <= wr_data;
                SRC_Y:   y_reg   <= wr_data;
                SRC_XX:  xx_reg  <= wr_data;
                SRC_YY:  yy_reg  <= wr_data;
                SRC_XY:  xy_reg  <= wr_data;
                SRC_R2:  r2_reg  <= wr_data;
                SRC_NUM: num_reg <= wr_data;
                SRC_DEN: den_reg <= wr_data;
                SRC_F:   f_reg   <= wr_data;
                SRC_T1:  t1_reg  <= wr_data;
                SRC_T2:  t2_reg  <= wr_data;
                SRC_DX:  dx_reg  <= wr_data;
                SRC_DY:  dy_reg  <= wr_data;
                SRC_TMP: tmp_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer and output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= 6'd0;
            cnt_reg       <= '0;
            clip_reg      <= 1'b0;
            fb_reg        <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // raise valid on a new result, release it once the downstream side takes it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        pc_reg    <= 6'd0;
                        cnt_reg   <= '0;
                        clip_reg  <= 1'b0;
                        fb_reg    <= 1'b0;
                        last_reg  <= last_point;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    unique case (uop.op)
                        OP_ADD:
                        begin
                            clip_reg <= clip_reg | sum_clip;
                            pc_reg   <= pc_reg + 6'd1;
                        end
                        OP_MUL,
                        OP_DIV:
                        begin
                            state_reg <= S_WAIT;
                        end
                        OP_LOOP:
                        begin
                            if (cnt_reg == n_eff)
                            begin
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                pc_reg <= pc_reg + 6'd1;
                            end
                        end
                        OP_CHK:
                        begin
                            if (fb_cond)
                            begin
                                fb_reg    <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                pc_reg <= pc_reg + 6'd1;
                            end
                        end
                        default:
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                            pc_reg  <= PC_LOOP;
                        end
                    endcase
                end
                S_WAIT:
                begin
                    if (mul_res.done || div_res.done)
                    begin
                        clip_reg  <= clip_reg | (mul_res.done ? mul_res.clip : div_res.clip);
                        pc_reg    <= pc_reg + 6'd1;
                        state_reg <= S_ISSUE;
                    end
                end
                default:
                begin
                    // hold the finished point until the output register frees up
                    if (out_load)
                    begin
                        out_x_reg     <= ox;
                        out_y_reg     <= oy;
                        out_fb_reg    <= fb_reg;
                        out_sat_reg   <= clip_reg | clip_x | clip_y;
                        out_last_reg  <= last_reg;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign norm_x         = out_x_reg;
    assign norm_y         = out_y_reg;
    assign fallback_taken = out_fb_reg;
    assign saturated      = out_sat_reg;
    assign last_out       = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("sequencer did not go busy after a request");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_res.done && div_res.done))
        else $error("multiplier and divider finished together");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output step");

    a_start_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_req.start || div_req.start) |=> (state_reg == S_WAIT))
        else $error("unit start without a wait step");

endmodule

/* tb/sv/lens_point_undistorter_test.sv */
// Self-checking testbench for lens_point_undistorter: directed table plus random phases,
// each result compared with a fixed-point undistortion predictor kept in this file or a table value.
// Depends on lpu_pkg and the lens_point_undistorter RTL.
module lens_point_undistorter_test
    import lpu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [63:0] q32_t;

    localparam q32_t       CAP_Q32     = CAPV;
    localparam q32_t       ONE_Q32     = ONEV;
    localparam int         ROUND_LIMIT = 31;
    localparam int         TOTAL_ITEMS = 1850;
    localparam int         QUIET_TAIL  = 150;
    localparam int         LONG_HOLD   = 3000;
    localparam logic [2:0] CFG_SPARE   = 3'd7;

    // Coefficient fields in Q3.18, 21 bits
    localparam logic [20:0] K_MINUS_ONE = 21'h1C0000;
    localparam logic [20:0] K_MINUS_TWO = 21'h180000;

    typedef struct {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic               fb;
        logic               sat;
        logic               last;
    } point_res_t;

    typedef struct {
        bit          cfg;
        logic [62:0] den;
        logic [62:0] num;
        logic [4:0]  iter;
        logic [15:0] bin;
        logic [15:0] sx;
        logic [15:0] sy;
        bit          last;
        bit          typed;
        logic [31:0] ex;
        logic [31:0] ey;
        bit          efb;
        bit          esat;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        src_x;
    logic [15:0]        src_y;
    logic               last_point;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic               fallback_taken;
    logic               saturated;
    logic               last_out;

    lens_point_undistorter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .src_x          (src_x),
        .src_y          (src_y),
        .last_point     (last_point),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .norm_x         (norm_x),
        .norm_y         (norm_y),
        .fallback_taken (fallback_taken),
        .saturated      (saturated),
        .last_out       (last_out)
    );

    // Shadow copy of the configuration registers
    logic [63:0] sh_inv_focal;
    logic [63:0] sh_center;
    logic [62:0] sh_rad_den;
    logic [62:0] sh_rad_num;
    logic [63:0] sh_tang;
    logic [4:0]  sh_iter;
    logic [15:0] sh_bin;

    point_res_t pending_points[$];
    int         error_count;
    int         items_sent;
    bit         quiet;
    bit         hold_req;
    bit         clip_seen;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Fixed-point predictor: signed Q32 in 64 bits, clamped to 2^60
    // ---------------------------------------------------------------
    function automatic logic [63:0] fx_mag(input q32_t a);
        return a < 0 ? 64'd0 - a : a;
    endfunction

    function automatic q32_t fx_add(input q32_t a, input q32_t b);
        q32_t s;
        s = a + b;
        if (s > CAP_Q32)
        begin
            clip_seen = 1'b1;
            return CAP_Q32;
        end
        if (s < -CAP_Q32)
        begin
            clip_seen = 1'b1;
            return -CAP_Q32;
        end
        return s;
    endfunction

    // Exact product, truncated toward zero
    function automatic q32_t fx_mul(input q32_t a, input q32_t b);
        logic [127:0] p;
        logic [63:0]  r;
        p = {64'd0, fx_mag(a)} * {64'd0, fx_mag(b)};
        p = p >> 32;
        if (p > {64'd0, CAPV})
        begin
            clip_seen = 1'b1;
            r = CAPV;
        end
        else
            r = p[63:0];
        return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
    endfunction

    // Magnitude quotient (mn * 2^32) / md, truncated
    function automatic q32_t fx_div(input logic [63:0] mn, input logic [63:0] md);
        logic [127:0] q;
        if (md == 64'd0)
        begin
            if (mn == 64'd0)
                return 0;
            clip_seen = 1'b1;
            return CAP_Q32;
        end
        q = ({64'd0, mn} << 32) / {64'd0, md};
        if (q > {64'd0, CAPV})
        begin
            clip_seen = 1'b1;
            return CAP_Q32;
        end
        return $signed(q[63:0]);
    endfunction

    function automatic q32_t k_field(input logic [62:0] regv, input int pos);
        logic [20:0] f;
        q32_t        k;
        f = regv >> pos;
        k = $signed(f);
        return k * 16384;
    endfunction

    // (coord*bin - center) * inverse focal; a zero bin counts as one
    function automatic q32_t pixel_to_norm(input logic [15:0] coord, input logic [7:0] bin,
                                           input logic [31:0] center, input logic [31:0] inv);
        q32_t d;
        q32_t b;
        b = (bin == 8'd0) ? 1 : $signed({56'd0, bin});
        d = $signed({48'd0, coord}) * b * 4096 - $signed({32'd0, center});
        return fx_mul(d * 65536, $signed({32'd0, inv}));
    endfunction

    // Round half away from zero to Q4.28, saturate to 32 bits
    function automatic logic [31:0] to_q428(input q32_t v);
        logic [63:0] m;
        m = (fx_mag(v) + 64'd8) >> 4;
        if (v >= 0 && m > 64'h7FFF_FFFF)
        begin
            clip_seen = 1'b1;
            m = 64'h7FFF_FFFF;
        end
        if (v < 0 && m > 64'h8000_0000)
        begin
            clip_seen = 1'b1;
            m = 64'h8000_0000;
        end
        return (v < 0) ? 32'd0 - m[31:0] : m[31:0];
    endfunction

    function automatic point_res_t undistort_point(input logic [15:0] sx, input logic [15:0] sy,
                                                   input logic lp);
        point_res_t res;
        q32_t k1, k2, k3, k4, k5, k6, p1, p2;
        q32_t x0, y0, x, y, xx, yy, xy, r2, num, den, f, t1, t2, dx, dy;
        int   rounds;
        logic fb;
        k1 = k_field(sh_rad_den, 42);
        k2 = k_field(sh_rad_den, 21);
        k3 = k_field(sh_rad_den, 0);
        k4 = k_field(sh_rad_num, 42);
        k5 = k_field(sh_rad_num, 21);
        k6 = k_field(sh_rad_num, 0);
        p1 = $signed(sh_tang[63:32]);
        p1 = p1 * 4;
        p2 = $signed(sh_tang[31:0]);
        p2 = p2 * 4;
        rounds = (sh_iter > ROUND_LIMIT) ? ROUND_LIMIT : sh_iter;
        fb = 1'b0;
        clip_seen = 1'b0;
        x0 = pixel_to_norm(sx, sh_bin[15:8], sh_center[63:32], sh_inv_focal[63:32]);
        y0 = pixel_to_norm(sy, sh_bin[7:0], sh_center[31:0], sh_inv_focal[31:0]);
        x = x0;
        y = y0;
        for (int j = 0; j < rounds; j++)
        begin
            xx = fx_mul(x, x);
            yy = fx_mul(y, y);
            xy = fx_mul(x, y);
            r2 = fx_add(xx, yy);
            num = fx_add(ONE_Q32, fx_mul(fx_add(fx_mul(fx_add(fx_mul(k6, r2), k5), r2), k4), r2));
            den = fx_add(ONE_Q32, fx_mul(fx_add(fx_mul(fx_add(fx_mul(k3, r2), k2), r2), k1), r2));
            // Negative radial factor: drop back to the plain normalized point
            if ((num < 0 && den > 0) || (num > 0 && den < 0) || (num < 0 && den == 0))
            begin
                x = x0;
                y = y0;
                fb = 1'b1;
                break;
            end
            f = fx_div(fx_mag(num), fx_mag(den));
            t1 = fx_mul(p1, xy);
            t2 = fx_mul(p2, xy);
            dx = fx_add(fx_add(t1, t1), fx_mul(p2, fx_add(r2, fx_add(xx, xx))));
            dy = fx_add(fx_mul(p1, fx_add(r2, fx_add(yy, yy))), fx_add(t2, t2));
            x = fx_mul(fx_add(x0, -dx), f);
            y = fx_mul(fx_add(y0, -dy), f);
        end
        res.nx = to_q428(x);
        res.ny = to_q428(y);
        res.fb = fb;
        res.sat = clip_seen;
        res.last = lp;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Configuration writes, block idle only
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_INV_FOCAL: sh_inv_focal = val;
            CFG_CENTER:    sh_center    = val;
            CFG_RAD_DEN:   sh_rad_den   = val[62:0];
            CFG_RAD_NUM:   sh_rad_num   = val[62:0];
            CFG_TANG:      sh_tang      = val;
            CFG_ITER:      sh_iter      = val[4:0];
            CFG_BIN:       sh_bin       = val[15:0];
            default:       ;
        endcase
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every expected point has come back, then let the bench settle
    task automatic drain_points();
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Offer one request and hold it until accepted; valid stays high into the next unless a gap is drawn
    task automatic send_point(input logic [15:0] sx, input logic [15:0] sy, input logic lp);
        in_valid   <= 1'b1;
        src_x      <= sx;
        src_y      <= sy;
        last_point <= lp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_points.push_back(undistort_point(sx, sy, lp));
        items_sent++;
        quiet = (items_sent >= TOTAL_ITEMS - QUIET_TAIL);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Small signed value packed into a 21-bit coefficient field
    function automatic logic [20:0] small_k(input int span);
        int v;
        v = $urandom_range(0, 2 * span) - span;
        return v[20:0];
    endfunction

    // ---------------------------------------------------------------
    // Result side: check each accepted result, stall for a long hold-off or in random bursts
    // ---------------------------------------------------------------
    int stall_left;
    int hold_left;

    always @(posedge clk)
    begin
        point_res_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_points.size() == 0)
                begin
                    $error("unexpected result x=%h y=%h", norm_x, norm_y);
                    error_count++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (norm_x !== want.nx)
                    begin
                        $error("norm_x expected %h actual %h", want.nx, norm_x);
                        error_count++;
                    end
                    if (norm_y !== want.ny)
                    begin
                        $error("norm_y expected %h actual %h", want.ny, norm_y);
                        error_count++;
                    end
                    if (fallback_taken !== want.fb)
                    begin
                        $error("fallback_taken expected %b actual %b", want.fb, fallback_taken);
                        error_count++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $error("saturated expected %b actual %b", want.sat, saturated);
                        error_count++;
                    end
                    if (last_out !== want.last)
                    begin
                        $error("last_out expected %b actual %b", want.last, last_out);
                        error_count++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            // Long hold-off first, then random bursts unless the tail is quiet
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------
    dir_row_t dir_rows[] = '{
        // Reset configuration: zero inverse focal gives the origin
        '{0, 63'd0, 63'd0, 5'd5, 16'h0101, 16'h0000, 16'h0000, 1'b0, 1, 32'h0, 32'h0, 0, 0},
        '{0, 63'd0, 63'd0, 5'd5, 16'h0101, 16'hFFFF, 16'hFFFF, 1'b1, 1, 32'h0, 32'h0, 0, 0},
        '{0, 63'd0, 63'd0, 5'd5, 16'h0101, 16'hFFFF, 16'h0000, 1'b0, 1, 32'h0, 32'h0, 0, 0},
        '{0, 63'd0, 63'd0, 5'd5, 16'h0101, 16'h0000, 16'hFFFF, 1'b1, 1, 32'h0, 32'h0, 0, 0},
        '{0, 63'd0, 63'd0, 5'd5, 16'h0101, 16'hAAAA, 16'h5555, 1'b0, 1, 32'h0, 32'h0, 0, 0},
        '{0, 63'd0, 63'd0, 5'd5, 16'h0101, 16'h5555, 16'hAAAA, 1'b1, 1, 32'h0, 32'h0, 0, 0},
        // Zero rounds: plain normalization, x0 = 1.0
        '{1, 63'd0, 63'd0, 5'd0, 16'h0101, 16'd32, 16'd0, 1'b0, 1, 32'h1000_0000, 32'h0, 0, 0},
        // Zero bin factor behaves as one
        '{1, 63'd0, 63'd0, 5'd0, 16'h0000, 16'd32, 16'd0, 1'b1, 1, 32'h1000_0000, 32'h0, 0, 0},
        // Zero denominator, positive numerator: factor clips, output clips
        '{1, {K_MINUS_ONE, 42'd0}, 63'd0, 5'd1, 16'h0101, 16'd32, 16'd0, 1'b0,
          1, 32'h7FFF_FFFF, 32'h0, 0, 1},
        // Zero denominator, zero numerator: factor is zero
        '{1, {K_MINUS_ONE, 42'd0}, {K_MINUS_ONE, 42'd0}, 5'd1, 16'h0101, 16'd32, 16'd0, 1'b1,
          1, 32'h0, 32'h0, 0, 0},
        // Zero denominator, negative numerator: fallback
        '{1, {K_MINUS_ONE, 42'd0}, {K_MINUS_TWO, 42'd0}, 5'd1, 16'h0101, 16'd32, 16'd0, 1'b0,
          1, 32'h1000_0000, 32'h0, 1, 0},
        // Negative numerator over positive denominator: fallback
        '{1, 63'd0, {K_MINUS_TWO, 42'd0}, 5'd3, 16'h0101, 16'd32, 16'd0, 1'b1,
          1, 32'h1000_0000, 32'h0, 1, 0},
        // Predicted rows: full round count, widest bins, extreme coordinates
        '{1, {21'h001000, 21'h000100, 21'h000010}, {21'h1FF000, 21'h000200, 21'h1FFFF0},
          5'd31, 16'h0302, 16'h1234, 16'h0567, 1'b0, 0, 32'h0, 32'h0, 0, 0},
        '{1, {21'h000400, 21'h1FFC00, 21'h000000}, {21'h000000, 21'h000100, 21'h000000},
          5'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0, 32'h0, 32'h0, 0, 0},
        '{1, {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF}, {21'h100000, 21'h100000, 21'h100000},
          5'd4, 16'h0101, 16'h0001, 16'h8000, 1'b0, 0, 32'h0, 32'h0, 0, 0}
    };

    // Random register settings for one phase; kind selects extremes
    task automatic setup_phase(input int kind, input logic [4:0] iter);
        logic [63:0] v;
        if (kind == 1)
        begin
            write_reg(CFG_INV_FOCAL, '1);
            write_reg(CFG_CENTER,    '1);
            write_reg(CFG_RAD_DEN,   '1);
            write_reg(CFG_RAD_NUM,   '1);
            write_reg(CFG_TANG,      '1);
            write_reg(CFG_BIN,       '1);
        end
        else if (kind == 2)
        begin
            write_reg(CFG_INV_FOCAL, '0);
            write_reg(CFG_CENTER,    '0);
            write_reg(CFG_RAD_DEN,   '0);
            write_reg(CFG_RAD_NUM,   '0);
            write_reg(CFG_TANG,      '0);
            write_reg(CFG_BIN,       '0);
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            write_reg(CFG_INV_FOCAL, rand64());
            write_reg(CFG_CENTER,    rand64());
            write_reg(CFG_RAD_DEN,   rand64());
            write_reg(CFG_RAD_NUM,   rand64());
            write_reg(CFG_TANG,      rand64());
            write_reg(CFG_BIN,       rand64());
        end
        else
        begin
            // Camera-like settings: focal of a few hundred pixels, modest distortion
            v = {$urandom_range(32'h0040_0000, 32'h0100_0000),
                 $urandom_range(32'h0040_0000, 32'h0100_0000)};
            write_reg(CFG_INV_FOCAL, v);
            v = {$urandom_range(0, 32'h0300_0000), $urandom_range(0, 32'h0200_0000)};
            write_reg(CFG_CENTER, v);
            write_reg(CFG_RAD_DEN, {1'b0, small_k(65536), small_k(16384), small_k(4096)});
            write_reg(CFG_RAD_NUM, {1'b0, small_k(65536), small_k(16384), small_k(4096)});
            v = {32'($urandom_range(0, 1 << 24)) - 32'(1 << 23),
                 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23)};
            write_reg(CFG_TANG, v);
            write_reg(CFG_BIN, {48'd0, 8'($urandom_range(1, 4)), 8'($urandom_range(1, 4))});
        end
        write_reg(CFG_ITER, {59'd0, iter});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE, rand64());
        end_writes();
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int          phase;
        int          count;
        int          pick;
        logic [4:0]  iter;
        logic [15:0] sx;
        logic [15:0] sy;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_INV_FOCAL;
        cfg_data     = '0;
        in_valid     = 1'b0;
        src_x        = '0;
        src_y        = '0;
        last_point   = 1'b0;
        out_stall    = 1'b0;
        error_count  = 0;
        items_sent   = 0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        stall_left   = 0;
        hold_left    = 0;
        sh_inv_focal = '0;
        sh_center    = '0;
        sh_rad_den   = '0;
        sh_rad_num   = '0;
        sh_tang      = '0;
        sh_iter      = 5'd5;
        sh_bin       = 16'd257;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: one request per row, register changes only with the block idle
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg)
            begin
                end_burst();
                drain_points();
                write_reg(CFG_INV_FOCAL, {32'h8000_0000, 32'h8000_0000});
                write_reg(CFG_CENTER,    '0);
                write_reg(CFG_TANG,      '0);
                write_reg(CFG_RAD_DEN,   {1'b0, dir_rows[i].den});
                write_reg(CFG_RAD_NUM,   {1'b0, dir_rows[i].num});
                write_reg(CFG_ITER,      {59'd0, dir_rows[i].iter});
                write_reg(CFG_BIN,       {48'd0, dir_rows[i].bin});
                write_reg(CFG_SPARE,     '1);
                end_writes();
            end
            send_point(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].last);
            if (dir_rows[i].typed)
            begin
                // Replace the predicted entry with the value read off the table
                pending_points[$].nx  = dir_rows[i].ex;
                pending_points[$].ny  = dir_rows[i].ey;
                pending_points[$].fb  = dir_rows[i].efb;
                pending_points[$].sat = dir_rows[i].esat;
            end
        end
        end_burst();

        // Random phases
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            drain_points();
            count = $urandom_range(20, 80);
            pick = $urandom_range(0, 19);
            if (phase == 0)
                iter = 5'd1;
            else if (phase == 1 || pick == 0)
            begin
                iter = 5'd31;
                count = $urandom_range(3, 8);
            end
            else if (phase == 2 || pick < 4)
                iter = 5'd0;
            else
                iter = $urandom_range(1, 4);
            setup_phase(phase == 1 ? 1 : (phase == 2 ? 2 : 0), iter);
            // Long receiver hold-off so the block fills up and stalls its input
            if (phase == 0)
                hold_req = 1'b1;
            if (count > TOTAL_ITEMS - items_sent)
                count = TOTAL_ITEMS - items_sent;
            for (int n = 0; n < count; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    sx = $urandom;
                    sy = $urandom;
                end
                else
                begin
                    sx = $urandom_range(0, 1280 * 16);
                    sy = $urandom_range(0, 960 * 16);
                end
                send_point(sx, sy, (n == count - 1) ? 1'b1 : 1'($urandom));
            end
            end_burst();
            phase++;
        end

        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Run limit: all points at the full round count, with stalls, several times over
    initial
    begin
        #120_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/lpu_pkg.sv
hdl/lpu_mul.sv
hdl/lpu_div.sv
hdl/lens_point_undistorter.sv
tb/sv/lens_point_undistorter_test.sv
